// ----- rtl/core/aoss_pkg.sv -----
// Shared constants, field widths and helper functions of the oversampling scan sequencer.
package aoss_pkg;

    // Design sizes
    localparam int NUM_SLOTS   = 8;
    localparam int SAMPLE_BITS = 10;
    localparam int OUT_BITS    = 15;

    // Channel list holds eight 4-bit channel numbers
    localparam int LIST_SLOTS  = 8;
    localparam int CHAN_W      = 4;
    localparam int LIST_W      = LIST_SLOTS * CHAN_W;
    localparam int SLOT_W      = 3;
    localparam int SLOT_CNT_W  = 4;
    localparam int OS_W        = 3;
    localparam int MAX_OS_LOG2 = 6;
    localparam int SUM_W       = 16;
    localparam int CNT_W       = 7;
    localparam int MUX_W       = 3;

    // Effective slot limit: smaller of NUM_SLOTS and the list size
    localparam int SLOT_MAX    = (NUM_SLOTS < LIST_SLOTS) ? NUM_SLOTS : LIST_SLOTS;

    // Stream word widths
    localparam int S_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W  = MUX_W + 1 + SLOT_W + OUT_BITS;
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_LIST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE_LOG2 = 2'd2;

    // Register reset values
    localparam logic [LIST_W-1:0]     CHANNEL_LIST_RST    = 32'h7654_3210;
    localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RST      = 4'd8;
    localparam logic [OS_W-1:0]       OVERSAMPLE_LOG2_RST = 3'd5;

    // Clamp the oversampling exponent to the largest supported value
    function automatic logic [OS_W-1:0] clamp_os(input logic [OS_W-1:0] os);
        logic [OS_W-1:0] res;
        res = os;
        if (os > OS_W'(MAX_OS_LOG2))
        begin
            res = OS_W'(MAX_OS_LOG2);
        end
        return res;
    endfunction

    // Number of slots in use: zero counts as one, capped at SLOT_MAX
    function automatic logic [SLOT_CNT_W-1:0] slot_limit(input logic [SLOT_CNT_W-1:0] cnt);
        logic [SLOT_CNT_W-1:0] res;
        res = cnt;
        if (cnt == '0)
        begin
            res = SLOT_CNT_W'(1);
        end
        else if (cnt > SLOT_CNT_W'(SLOT_MAX))
        begin
            res = SLOT_CNT_W'(SLOT_MAX);
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/aoss_scale.sv -----
// Scaling shifter: brings an oversampled sum to the output width.
module aoss_scale
(
    input  logic [aoss_pkg::SUM_W-1:0]    sum,
    input  logic [aoss_pkg::OS_W-1:0]     os,
    output logic [aoss_pkg::OUT_BITS-1:0] average
);

    localparam int TOTAL_W = aoss_pkg::SUM_W + aoss_pkg::OUT_BITS;
    localparam int SH_W    = 5;

    logic [SH_W-1:0]    total;
    logic [SH_W-1:0]    shift_left;
    logic [SH_W-1:0]    shift_right;
    logic [TOTAL_W-1:0] widened;
    logic [TOTAL_W-1:0] shifted;

    // Work out direction and distance of the shift
    always_comb
    begin
        total       = SH_W'(aoss_pkg::SAMPLE_BITS) + SH_W'(os);
        shift_left  = '0;
        shift_right = '0;
        if (total < SH_W'(aoss_pkg::OUT_BITS))
        begin
            shift_left = SH_W'(aoss_pkg::OUT_BITS) - total;
        end
        else if (total > SH_W'(aoss_pkg::OUT_BITS))
        begin
            shift_right = total - SH_W'(aoss_pkg::OUT_BITS);
        end
    end

    // Shift and keep the low output bits
    assign widened = TOTAL_W'(sum);
    assign shifted = (widened << shift_left) >> shift_right;
    assign average = shifted[aoss_pkg::OUT_BITS-1:0];

endmodule

// ----- rtl/core/adc_oversampling_scan_sequencer.sv -----
// Top level of the oversampling round-robin converter scan sequencer.
// Each accepted sample word loads the registered result word shown on m_tdata.
// Throughput: one sample word per cycle while s_tready is high; the accumulate, count and compare step is the loop.
// The result register frees up in the cycle it is taken, so s_tready stays high unless
// a result waits while m_tready is low.
// Reset (rst_n low, asynchronous): slot 0, sum and count cleared, registers to defaults.
module adc_oversampling_scan_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [aoss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aoss_pkg::LIST_W-1:0]       cfg_data,
    // Sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [aoss_pkg::S_DATA_W-1:0]     s_tdata,  // sample[9:0], zero fill
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [aoss_pkg::M_DATA_W-1:0]     m_tdata,  // next_mux[2:0], next_bank[3],
                                                        // done_slot[6:4], average[21:7], zero fill
    output logic                              m_tuser   // done_res
);

    // Configuration registers
    logic [aoss_pkg::LIST_W-1:0]     channel_list_reg;
    logic [aoss_pkg::SLOT_CNT_W-1:0] slot_count_reg;
    logic [aoss_pkg::OS_W-1:0]       oversample_log2_reg;

    // Scan state
    logic [aoss_pkg::SLOT_W-1:0] slot_position_reg, slot_position_next;
    logic [aoss_pkg::SUM_W-1:0]  running_sum_reg, running_sum_next;
    logic [aoss_pkg::CNT_W-1:0]  sample_count_reg, sample_count_next;

    // Result register
    logic                          out_valid_reg, out_valid_next;
    logic [aoss_pkg::MUX_W-1:0]    next_mux_reg, next_mux_next;
    logic                          next_bank_reg, next_bank_next;
    logic                          done_res_reg, done_res_next;
    logic [aoss_pkg::SLOT_W-1:0]   done_slot_reg, done_slot_next;
    logic [aoss_pkg::OUT_BITS-1:0] average_reg, average_next;

    // Step logic
    logic                            s_fire;
    logic [aoss_pkg::SAMPLE_BITS-1:0] sample;
    logic [aoss_pkg::OS_W-1:0]       os_eff;
    logic [aoss_pkg::SUM_W-1:0]      sum_acc;
    logic [aoss_pkg::CNT_W-1:0]      cnt_acc;
    logic [aoss_pkg::CNT_W-1:0]      target;
    logic                            done;
    logic [aoss_pkg::SLOT_CNT_W-1:0] slot_inc;
    logic [aoss_pkg::OUT_BITS-1:0]   scaled;
    logic [aoss_pkg::CHAN_W-1:0]     chan;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign sample    = s_tdata[aoss_pkg::SAMPLE_BITS-1:0];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_list_reg    <= aoss_pkg::CHANNEL_LIST_RST;
            slot_count_reg      <= aoss_pkg::SLOT_COUNT_RST;
            oversample_log2_reg <= aoss_pkg::OVERSAMPLE_LOG2_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aoss_pkg::CFG_CHANNEL_LIST:
                begin
                    channel_list_reg <= cfg_data;
                end
                aoss_pkg::CFG_SLOT_COUNT:
                begin
                    slot_count_reg <= cfg_data[aoss_pkg::SLOT_CNT_W-1:0];
                end
                aoss_pkg::CFG_OVERSAMPLE_LOG2:
                begin
                    oversample_log2_reg <= cfg_data[aoss_pkg::OS_W-1:0];
                end
                default:
                begin
                    // Drop writes to unused indexes
                end
            endcase
        end
    end

    // Scale the finished sum
    aoss_scale u_scale
    (
        .sum     (sum_acc),
        .os      (os_eff),
        .average (scaled)
    );

    // Accumulate, count, compare and advance the slot
    always_comb
    begin
        os_eff   = aoss_pkg::clamp_os(oversample_log2_reg);
        sum_acc  = running_sum_reg + aoss_pkg::SUM_W'(sample);
        cnt_acc  = sample_count_reg + aoss_pkg::CNT_W'(1);
        target   = aoss_pkg::CNT_W'(1) << os_eff;
        done     = (cnt_acc >= target);
        slot_inc = aoss_pkg::SLOT_CNT_W'(slot_position_reg) + aoss_pkg::SLOT_CNT_W'(1);

        slot_position_next = slot_position_reg;
        running_sum_next   = running_sum_reg;
        sample_count_next  = sample_count_reg;
        if (s_fire)
        begin
            running_sum_next  = sum_acc;
            sample_count_next = cnt_acc;
            if (done)
            begin
                running_sum_next  = '0;
                sample_count_next = '0;
                if (slot_inc >= aoss_pkg::slot_limit(slot_count_reg))
                begin
                    slot_position_next = '0;
                end
                else
                begin
                    slot_position_next = slot_inc[aoss_pkg::SLOT_W-1:0];
                end
            end
        end
    end

    // Build the result word for the accepted sample
    always_comb
    begin
        chan           = channel_list_reg[slot_position_next * aoss_pkg::CHAN_W +: aoss_pkg::CHAN_W];
        next_mux_next  = chan[aoss_pkg::MUX_W-1:0];
        next_bank_next = chan[aoss_pkg::CHAN_W-1];
        done_res_next  = done;
        done_slot_next = done ? slot_position_reg : '0;
        average_next   = done ? scaled : '0;
        out_valid_next = out_valid_reg;
        if (s_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_position_reg <= '0;
            running_sum_reg   <= '0;
            sample_count_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            slot_position_reg <= slot_position_next;
            running_sum_reg   <= running_sum_next;
            sample_count_reg  <= sample_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Load the result word on each accepted sample
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            next_mux_reg  <= next_mux_next;
            next_bank_reg <= next_bank_next;
            done_res_reg  <= done_res_next;
            done_slot_reg <= done_slot_next;
            average_reg   <= average_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = done_res_reg;
    assign m_tdata  = aoss_pkg::M_DATA_W'({average_reg, done_slot_reg, next_bank_reg, next_mux_reg});

    // Count never passes the largest oversampling target
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sample_count_reg <= aoss_pkg::CNT_W'(1 << aoss_pkg::MAX_OS_LOG2))
        else $error("sample count beyond largest target");

    // A completed average clears the sum and count
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && done |=> running_sum_reg == '0 && sample_count_reg == '0)
        else $error("sum or count not cleared after completion");

    // A completed average reports the slot that was current
    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && done |=> done_slot_reg == $past(slot_position_reg) && done_res_reg)
        else $error("completed slot mismatch");

    // Without completion the slot and value fields stay zero
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> done_slot_reg == '0 && average_reg == '0)
        else $error("result fields set without completion");

    // A sample accepted while a result waits would overwrite it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !s_tready)
        else $error("sample accepted over a stalled result");

endmodule
